>>> design/park_pkg.sv
package park_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF  = 16;

  // Horner steps after the top coefficient (C9, C7, C5, C3, C1)
  localparam int HORNER_STEPS = 5;

  typedef logic [30:0] fix30_t;  // Q30, 1.0 = quarter turn
  typedef logic [31:0] poly_t;   // Q30 polynomial partial value

  // one sine evaluation in flight
  typedef struct packed {
    logic   neg;  // result negated (lower half turn)
    fix30_t x;
    fix30_t x2;
    poly_t  p;
  } sine_lane_t;

  localparam poly_t POLY_C11 = 32'd3864;

  localparam poly_t POLY_COEF [HORNER_STEPS] = '{
    32'd172273, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

endpackage

>>> design/park_front.sv
module park_front import park_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [ANGLE_BITS-1:0]    angle_i,
  input  logic [3*SAMPLE_BITS-1:0] smp_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output sine_lane_t               sin_o,
  output sine_lane_t               cos_o,
  output logic [3*SAMPLE_BITS-1:0] smp_o
);

  localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QUARTER_M = (ANGLE_BITS - 1)'(1) << (ANGLE_BITS - 2);

  // fold angle into first quadrant, scale to Q30
  function automatic sine_lane_t fold(input logic [ANGLE_BITS-1:0] pos);
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] r;
    logic [ANGLE_BITS-2:0] m;
    sine_lane_t            l;
    quad  = pos[ANGLE_BITS-1 -: 2];
    r     = {1'b0, pos[ANGLE_BITS-3:0]};
    m     = quad[0] ? (QUARTER_M - r) : r;
    l.neg = quad[1];
    l.x   = 31'(m) << (32 - ANGLE_BITS);
    l.x2  = '0;
    l.p   = POLY_C11;
    return l;
  endfunction

  logic [1:0] vld_q;
  logic [2:0] rdy;

  sine_lane_t               sin_a_q, cos_a_q, sin_b_q, cos_b_q;
  sine_lane_t               sin_sq, cos_sq;
  logic [3*SAMPLE_BITS-1:0] smp_a_q, smp_b_q;
  logic [61:0]              sq_sin, sq_cos;

  assign rdy[2] = ready_i;
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_comb begin
    sq_sin    = 62'(sin_a_q.x) * 62'(sin_a_q.x);
    sq_cos    = 62'(cos_a_q.x) * 62'(cos_a_q.x);
    sin_sq    = sin_a_q;
    sin_sq.x2 = sq_sin[60:30];
    cos_sq    = cos_a_q;
    cos_sq.x2 = sq_cos[60:30];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sin_a_q <= fold(angle_i);
      cos_a_q <= fold(angle_i + QUARTER);
      smp_a_q <= smp_i;
    end
    if (rdy[1]) begin
      sin_b_q <= sin_sq;
      cos_b_q <= cos_sq;
      smp_b_q <= smp_a_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[1];
  assign sin_o   = sin_b_q;
  assign cos_o   = cos_b_q;
  assign smp_o   = smp_b_q;

endmodule

>>> design/park_horner_cell.sv
module park_horner_cell import park_pkg::*; #(
  parameter int    SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter poly_t COEF        = POLY_C11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  sine_lane_t               sin_i,
  input  sine_lane_t               cos_i,
  input  logic [3*SAMPLE_BITS-1:0] smp_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output sine_lane_t               sin_o,
  output sine_lane_t               cos_o,
  output logic [3*SAMPLE_BITS-1:0] smp_o
);

  // p = COEF - x2*p >> 30
  function automatic sine_lane_t step(input sine_lane_t l);
    logic [62:0] prod;
    sine_lane_t  r;
    prod = 63'(l.x2) * 63'(l.p);
    r    = l;
    r.p  = COEF - prod[61:30];
    return r;
  endfunction

  logic                     valid_q;
  sine_lane_t               sin_q, cos_q;
  logic [3*SAMPLE_BITS-1:0] smp_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      sin_q <= step(sin_i);
      cos_q <= step(cos_i);
      smp_q <= smp_i;
    end
  end

  assign valid_o = valid_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign smp_o   = smp_q;

endmodule

>>> design/park_back.sv
module park_back import park_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  sine_lane_t                    sin_i,
  input  sine_lane_t                    cos_i,
  input  logic [3*SAMPLE_BITS-1:0]      smp_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [SAMPLE_BITS:0]   q_o,
  output logic signed [SAMPLE_BITS:0]   d_o,
  output logic signed [SAMPLE_BITS-1:0] z_o
);

  localparam int SB       = SAMPLE_BITS;
  localparam int NSTG     = 6;
  localparam int SIN_W    = 26;             // Q24 signed
  localparam int MH_W     = SIN_W + 32;
  localparam int WEIGHT_W = 27;
  localparam int PROD_W   = SB + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int U_W      = SUM_W - 24;     // biased quotient input
  localparam int K        = U_W + 2;
  localparam int UZ_W     = SB + 2;
  localparam int KZ       = UZ_W + 2;
  localparam int QS_W     = SB + 4;

  localparam logic signed [31:0]     SQRT3_Q30 = 32'sd1859775393;
  localparam logic signed [MH_W-1:0] H_BIAS    = MH_W'(64'd1 << 29);
  localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'(64'd3 << 23);
  localparam logic [U_W-1:0]   U_BIAS  = U_W'(64'd3 << (SB + 2));
  localparam logic [UZ_W-1:0]  UZ_BIAS = UZ_W'((64'd3 << (SB - 1)) + 64'd1);
  localparam logic [K-2:0]     RECIP   = (K - 1)'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [KZ-2:0]    RECIPZ  = (KZ - 1)'(((64'd1 << KZ) + 64'd2) / 64'd3);
  localparam logic signed [QS_W-1:0] Q_BIAS = QS_W'(64'd1 << (SB + 2));
  localparam logic signed [QS_W-1:0] SAT_LO = -QS_W'(64'd1 << SB);
  localparam logic signed [QS_W-1:0] SAT_HI = QS_W'((64'd1 << SB) - 64'd1);

  typedef logic signed [SIN_W-1:0]    sin_t;
  typedef logic signed [WEIGHT_W-1:0] wgt_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  function automatic sin_t finish(input sine_lane_t l);
    logic [62:0] prod;
    logic [32:0] t;
    sin_t        s;
    prod = 63'(l.x) * 63'(l.p);
    t    = prod[62:30] + 33'd32;
    s    = $signed({1'b0, t[30:6]});
    return l.neg ? -s : s;
  endfunction

  function automatic sin_t mul_sqrt3(input sin_t v);
    logic signed [MH_W-1:0] m;
    m = MH_W'(SQRT3_Q30) * MH_W'(v) + H_BIAS;
    return m[55:30];
  endfunction

  function automatic logic signed [SB:0] sat(input logic [SB+2:0] qv);
    logic signed [QS_W-1:0] v;
    v = $signed({1'b0, qv}) - Q_BIAS;
    if (v < SAT_LO) return SAT_LO[SB:0];
    if (v > SAT_HI) return SAT_HI[SB:0];
    return v[SB:0];
  endfunction

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;

  // stage payloads
  sin_t                 s1_sin_q, s1_cos_q, s2_sin_q, s2_cos_q, s2_h_q, s2_g_q;
  logic [3*SB-1:0]      s1_smp_q, s2_smp_q, s3_smp_q;
  prod_t                s3_qa_q, s3_qb_q, s3_qc_q, s3_da_q, s3_db_q, s3_dc_q;
  logic [U_W-1:0]       s4_uq_q, s4_ud_q;
  logic [UZ_W-1:0]      s4_uz_q;
  logic [SB+2:0]        s5_qq_q, s5_qd_q;
  logic [SB-1:0]        s5_qz_q;
  logic signed [SB:0]   q_q, d_q;
  logic signed [SB-1:0] z_q;

  // combinational terms
  wgt_t                 w_qa, w_qb, w_qc, w_da, w_db, w_dc;
  logic signed [SB-1:0] a2, b2, c2, a3, b3, c3;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [U_W-1:0]       u_q, u_d;
  logic [UZ_W-1:0]      u_z;
  logic [U_W+K-2:0]     pq, pd;
  logic [UZ_W+KZ-2:0]   pz;

  assign rdy[NSTG] = ready_i;
  for (genvar i = 0; i < NSTG; i++) begin : g_rdy
    assign rdy[i] = !vld_q[i] || rdy[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_comb begin
    a2   = $signed(s2_smp_q[SB-1:0]);
    b2   = $signed(s2_smp_q[2*SB-1:SB]);
    c2   = $signed(s2_smp_q[3*SB-1:2*SB]);
    // twice the phase weights
    w_qa = WEIGHT_W'(s2_cos_q) + WEIGHT_W'(s2_cos_q);
    w_qb = WEIGHT_W'(s2_h_q) - WEIGHT_W'(s2_cos_q);
    w_qc = -WEIGHT_W'(s2_cos_q) - WEIGHT_W'(s2_h_q);
    w_da = WEIGHT_W'(s2_sin_q) + WEIGHT_W'(s2_sin_q);
    w_db = -WEIGHT_W'(s2_sin_q) - WEIGHT_W'(s2_g_q);
    w_dc = WEIGHT_W'(s2_g_q) - WEIGHT_W'(s2_sin_q);

    a3   = $signed(s3_smp_q[SB-1:0]);
    b3   = $signed(s3_smp_q[2*SB-1:SB]);
    c3   = $signed(s3_smp_q[3*SB-1:2*SB]);
    sum_q = SUM_W'(s3_qa_q) + SUM_W'(s3_qb_q) + SUM_W'(s3_qc_q) + SUM_BIAS;
    sum_d = SUM_W'(s3_da_q) + SUM_W'(s3_db_q) + SUM_W'(s3_dc_q) + SUM_BIAS;
    // floor(sum / 2^24) moved to a nonnegative range
    u_q  = sum_q[SUM_W-1:24] + U_BIAS;
    u_d  = sum_d[SUM_W-1:24] + U_BIAS;
    u_z  = UZ_W'(a3) + UZ_W'(b3) + UZ_W'(c3) + UZ_BIAS;

    // divide by 3 through reciprocal
    pq = (U_W + K - 1)'(s4_uq_q) * (U_W + K - 1)'(RECIP);
    pd = (U_W + K - 1)'(s4_ud_q) * (U_W + K - 1)'(RECIP);
    pz = (UZ_W + KZ - 1)'(s4_uz_q) * (UZ_W + KZ - 1)'(RECIPZ);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_sin_q <= finish(sin_i);
      s1_cos_q <= finish(cos_i);
      s1_smp_q <= smp_i;
    end
    if (rdy[1]) begin
      s2_sin_q <= s1_sin_q;
      s2_cos_q <= s1_cos_q;
      s2_h_q   <= mul_sqrt3(s1_sin_q);
      s2_g_q   <= mul_sqrt3(s1_cos_q);
      s2_smp_q <= s1_smp_q;
    end
    if (rdy[2]) begin
      s3_qa_q  <= PROD_W'(w_qa) * PROD_W'(a2);
      s3_qb_q  <= PROD_W'(w_qb) * PROD_W'(b2);
      s3_qc_q  <= PROD_W'(w_qc) * PROD_W'(c2);
      s3_da_q  <= PROD_W'(w_da) * PROD_W'(a2);
      s3_db_q  <= PROD_W'(w_db) * PROD_W'(b2);
      s3_dc_q  <= PROD_W'(w_dc) * PROD_W'(c2);
      s3_smp_q <= s2_smp_q;
    end
    if (rdy[3]) begin
      s4_uq_q <= u_q;
      s4_ud_q <= u_d;
      s4_uz_q <= u_z;
    end
    if (rdy[4]) begin
      s5_qq_q <= pq[K+SB+2:K];
      s5_qd_q <= pd[K+SB+2:K];
      s5_qz_q <= pz[KZ+SB-1:KZ];
    end
    if (rdy[5]) begin
      q_q <= sat(s5_qq_q);
      d_q <= sat(s5_qd_q);
      z_q <= $signed({~s5_qz_q[SB-1], s5_qz_q[SB-2:0]});
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NSTG-1];
  assign q_o     = q_q;
  assign d_o     = d_q;
  assign z_o     = z_q;

endmodule

>>> design/park_transform_abc_to_dq0.sv
// Park transform, abc -> q, d, zero sequence (amplitude invariant).
// Input stream s_axis: one item = rotor angle plus three Q15 phase samples.
// Output stream m_axis: one item = q_axis, d_axis (one extra integer bit,
// saturated) and zero_seq, per input item, in input order.
// Throughput: one item per cycle while m_axis is ready. Each stage is a cell
// with its own valid bit; a cell loads whenever it is empty or its successor
// moves, so bubbles close up and items keep entering while the output is held.
// Depth: 2 angle/square cells, 5 Horner cells and 6 finishing cells lie between
// input accept and output valid, set by the sine polynomial chain plus the
// weighting, divide-by-3 and saturation stages.
// Stall: when m_axis_tready_i is low the output register holds its item;
// upstream cells keep filling until the chain is full, then s_axis_tready_o
// drops. Nothing is lost or repeated.
// Reset (rst_ni low, async): all valid bits clear, the chain is empty and
// s_axis_tready_o is high right after reset. No other state.
module park_transform_abc_to_dq0 import park_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // angle, phase_a, phase_b, phase_c (lowest bit up), zero padded
  input  logic [((ANGLE_BITS+3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // q_axis, d_axis, zero_seq (lowest bit up), zero padded
  output logic [((3*SAMPLE_BITS+2+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((3*SB + 2 + 7) / 8) * 8;

  // cell chain links: index 0 = front output, HORNER_STEPS = last Horner cell
  logic                 ch_valid [HORNER_STEPS+1];
  logic                 ch_ready [HORNER_STEPS+1];
  sine_lane_t           ch_sin   [HORNER_STEPS+1];
  sine_lane_t           ch_cos   [HORNER_STEPS+1];
  logic [3*SB-1:0]      ch_smp   [HORNER_STEPS+1];

  logic signed [SB:0]   q_axis, d_axis;
  logic signed [SB-1:0] zero_seq;

  park_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid_i),
    .ready_o(s_axis_tready_o),
    .angle_i(s_axis_tdata_i[ANGLE_BITS-1:0]),
    .smp_i  (s_axis_tdata_i[ANGLE_BITS +: 3*SB]),
    .valid_o(ch_valid[0]),
    .ready_i(ch_ready[0]),
    .sin_o  (ch_sin[0]),
    .cos_o  (ch_cos[0]),
    .smp_o  (ch_smp[0])
  );

  // sine polynomial: one Horner step per cell
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    park_horner_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF       (POLY_COEF[i])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(ch_valid[i]),
      .ready_o(ch_ready[i]),
      .sin_i  (ch_sin[i]),
      .cos_i  (ch_cos[i]),
      .smp_i  (ch_smp[i]),
      .valid_o(ch_valid[i+1]),
      .ready_i(ch_ready[i+1]),
      .sin_o  (ch_sin[i+1]),
      .cos_o  (ch_cos[i+1]),
      .smp_o  (ch_smp[i+1])
    );
  end

  park_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(ch_valid[HORNER_STEPS]),
    .ready_o(ch_ready[HORNER_STEPS]),
    .sin_i  (ch_sin[HORNER_STEPS]),
    .cos_i  (ch_cos[HORNER_STEPS]),
    .smp_i  (ch_smp[HORNER_STEPS]),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .q_o    (q_axis),
    .d_o    (d_axis),
    .z_o    (zero_seq)
  );

  assign m_axis_tdata_o = OUT_W'({zero_seq, d_axis, q_axis});

endmodule
